// ===== rtl/sale_pkg.sv =====
// Package for the shifting array list engine: sizes, codes, state and
// command/status structs shared by the controller, datapath and top level.
// No dependencies.
`timescale 1ns / 1ps

package sale_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FND_W  = 7;
  localparam int TOT_W  = 7;
  localparam int CAP_W  = 7;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_READ      = 3'd3,
    CMD_OVERWRITE = 3'd4,
    CMD_FIND      = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_RD_WAIT,
    S_FIND_RD,
    S_FIND_CMP
  } state_t;

  typedef enum logic [1:0] {
    RA_POS,
    RA_PTR,
    RA_PTR_DN,
    RA_PTR_UP
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_TAIL,
    WR_POS,
    WR_SHIFT
  } wr_sel_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_RDFAIL,
    RES_READ,
    RES_FOUND,
    RES_NOTFOUND
  } res_sel_t;

  typedef struct packed {
    logic     latch;
    logic     mem_rd;
    rd_sel_t  rd_sel;
    logic     mem_wr;
    wr_sel_t  wr_sel;
    logic     ptr_load_count;
    logic     ptr_load_pos;
    logic     ptr_load_zero;
    logic     ptr_dec;
    logic     ptr_inc;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     finish;
    status_t  status;
    res_sel_t res_sel;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic pos_above_count;
    logic pos_out;
    logic ptr_above_pos;
    logic shift_more;
    logic scan_more;
    logic match;
  } stat_t;

  function automatic logic [DATA_WIDTH-1:0] to_word(input logic [VAL_W-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
    logic signed [63:0] ext;
    ext = 64'(signed'(w));
    return ext[VAL_W-1:0];
  endfunction

endpackage

// ===== rtl/sale_ctrl.sv =====
// Controller state machine for the shifting array list engine.
// Depends on sale_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps

module sale_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sale_pkg::stat_t stat,
  output sale_pkg::ctrl_t ctrl
);
  import sale_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (stat.cmd)
          CMD_INSERT: begin
            if (!stat.full && !stat.pos_above_count) begin
              state_next = S_INS_RD;
            end
          end
          CMD_DELETE: begin
            if (!stat.empty && !stat.pos_out) begin
              state_next = S_DEL_RD;
            end
          end
          CMD_READ: begin
            if (!stat.empty && !stat.pos_out) begin
              state_next = S_RD_WAIT;
            end
          end
          CMD_FIND: state_next = S_FIND_RD;
          default: state_next = S_IDLE;
        endcase
      end
      S_INS_RD:   state_next = stat.ptr_above_pos ? S_INS_WR : S_IDLE;
      S_INS_WR:   state_next = S_INS_RD;
      S_DEL_RD:   state_next = stat.shift_more ? S_DEL_WR : S_IDLE;
      S_DEL_WR:   state_next = S_DEL_RD;
      S_RD_WAIT:  state_next = S_IDLE;
      S_FIND_RD:  state_next = stat.scan_more ? S_FIND_CMP : S_IDLE;
      S_FIND_CMP: state_next = stat.match ? S_IDLE : S_FIND_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        ctrl.latch = start;
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_APPEND: begin
            ctrl.finish = 1'b1;
            if (stat.full) begin
              ctrl.status = ST_FULL;
            end else begin
              ctrl.mem_wr  = 1'b1;
              ctrl.wr_sel  = WR_TAIL;
              ctrl.cnt_inc = 1'b1;
            end
          end
          CMD_INSERT: begin
            if (stat.full) begin
              ctrl.finish = 1'b1;
              ctrl.status = ST_FULL;
            end else if (stat.pos_above_count) begin
              ctrl.finish = 1'b1;
              ctrl.status = ST_INVALID;
            end else begin
              ctrl.ptr_load_count = 1'b1;
            end
          end
          CMD_DELETE: begin
            if (stat.empty) begin
              ctrl.finish = 1'b1;
              ctrl.status = ST_EMPTY;
            end else if (stat.pos_out) begin
              ctrl.finish = 1'b1;
              ctrl.status = ST_INVALID;
            end else begin
              ctrl.ptr_load_pos = 1'b1;
            end
          end
          CMD_READ: begin
            if (stat.empty) begin
              ctrl.finish  = 1'b1;
              ctrl.status  = ST_EMPTY;
              ctrl.res_sel = RES_RDFAIL;
            end else if (stat.pos_out) begin
              ctrl.finish  = 1'b1;
              ctrl.status  = ST_INVALID;
              ctrl.res_sel = RES_RDFAIL;
            end else begin
              ctrl.mem_rd = 1'b1;
              ctrl.rd_sel = RA_POS;
            end
          end
          CMD_OVERWRITE: begin
            ctrl.finish = 1'b1;
            if (stat.empty) begin
              ctrl.status = ST_EMPTY;
            end else if (stat.pos_out) begin
              ctrl.status = ST_INVALID;
            end else begin
              ctrl.mem_wr = 1'b1;
              ctrl.wr_sel = WR_POS;
            end
          end
          CMD_FIND: begin
            ctrl.ptr_load_zero = 1'b1;
          end
          default: begin
            ctrl.finish = 1'b1;
          end
        endcase
      end
      S_INS_RD: begin
        if (stat.ptr_above_pos) begin
          ctrl.mem_rd = 1'b1;
          ctrl.rd_sel = RA_PTR_DN;
        end else begin
          ctrl.mem_wr  = 1'b1;
          ctrl.wr_sel  = WR_POS;
          ctrl.cnt_inc = 1'b1;
          ctrl.finish  = 1'b1;
        end
      end
      S_INS_WR: begin
        ctrl.mem_wr  = 1'b1;
        ctrl.wr_sel  = WR_SHIFT;
        ctrl.ptr_dec = 1'b1;
      end
      S_DEL_RD: begin
        if (stat.shift_more) begin
          ctrl.mem_rd = 1'b1;
          ctrl.rd_sel = RA_PTR_UP;
        end else begin
          ctrl.cnt_dec = 1'b1;
          ctrl.finish  = 1'b1;
        end
      end
      S_DEL_WR: begin
        ctrl.mem_wr  = 1'b1;
        ctrl.wr_sel  = WR_SHIFT;
        ctrl.ptr_inc = 1'b1;
      end
      S_RD_WAIT: begin
        ctrl.finish  = 1'b1;
        ctrl.res_sel = RES_READ;
      end
      S_FIND_RD: begin
        if (stat.scan_more) begin
          ctrl.mem_rd = 1'b1;
          ctrl.rd_sel = RA_PTR;
        end else begin
          ctrl.finish  = 1'b1;
          ctrl.res_sel = RES_NOTFOUND;
        end
      end
      S_FIND_CMP: begin
        if (stat.match) begin
          ctrl.finish  = 1'b1;
          ctrl.res_sel = RES_FOUND;
        end else begin
          ctrl.ptr_inc = 1'b1;
        end
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

// ===== rtl/sale_datapath.sv =====
// Datapath for the shifting array list engine: cell memory, count,
// capacity register, scan pointer and result registers.
// Depends on sale_pkg for sizes, codes, structs and word conversion.
`timescale 1ns / 1ps

module sale_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sale_pkg::CMD_W-1:0]    cmd,
  input  logic [sale_pkg::POS_W-1:0]    position,
  input  logic signed [sale_pkg::VAL_W-1:0] value,
  input  logic                          cfg_we,
  input  logic [sale_pkg::CAP_W-1:0]    cfg_wdata,
  input  sale_pkg::ctrl_t               ctrl,
  output sale_pkg::stat_t               stat,
  output logic                          done,
  output logic [sale_pkg::STAT_W-1:0]   status,
  output logic signed [sale_pkg::VAL_W-1:0] read_value,
  output logic signed [sale_pkg::FND_W-1:0] found_position,
  output logic [sale_pkg::TOT_W-1:0]    element_total,
  output logic                          is_empty,
  output logic                          is_full
);
  import sale_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;

  logic [CAP_W-1:0]      cap;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CMP_W-1:0]      ptr;
  logic [CMP_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] word_q;
  cmd_t                  cmd_q;

  logic [CMP_W-1:0]      cap_eff;
  logic [CMP_W-1:0]      count_ext;
  logic [CMP_W-1:0]      count_next_ext;
  logic [CMP_W-1:0]      ptr_dn;
  logic [CMP_W-1:0]      ptr_up;
  logic [IDX_W-1:0]      raddr;
  logic [IDX_W-1:0]      waddr;
  logic [DATA_WIDTH-1:0] wdata;

  assign ptr_dn    = ptr - CMP_W'(1);
  assign ptr_up    = ptr + CMP_W'(1);
  assign count_ext = CMP_W'(count);
  assign cap_eff   = (CMP_W'(cap) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap);

  always_comb begin
    count_next = count;
    if (ctrl.cnt_inc) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.cnt_dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign count_next_ext = CMP_W'(count_next);

  always_comb begin
    stat.cmd             = cmd_q;
    stat.full            = (count_ext >= cap_eff);
    stat.empty           = (count == '0);
    stat.pos_above_count = (pos_q > count_ext);
    stat.pos_out         = (pos_q >= count_ext);
    stat.ptr_above_pos   = (ptr > pos_q);
    stat.shift_more      = (ptr_up < count_ext);
    stat.scan_more       = (ptr < count_ext);
    stat.match           = (rdata == word_q);
  end

  always_comb begin
    case (ctrl.rd_sel)
      RA_POS:    raddr = pos_q[IDX_W-1:0];
      RA_PTR:    raddr = ptr[IDX_W-1:0];
      RA_PTR_DN: raddr = ptr_dn[IDX_W-1:0];
      RA_PTR_UP: raddr = ptr_up[IDX_W-1:0];
      default:   raddr = ptr[IDX_W-1:0];
    endcase
  end

  always_comb begin
    case (ctrl.wr_sel)
      WR_TAIL: begin
        waddr = count_ext[IDX_W-1:0];
        wdata = word_q;
      end
      WR_POS: begin
        waddr = pos_q[IDX_W-1:0];
        wdata = word_q;
      end
      WR_SHIFT: begin
        waddr = ptr[IDX_W-1:0];
        wdata = rdata;
      end
      default: begin
        waddr = ptr[IDX_W-1:0];
        wdata = rdata;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_wr) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.mem_rd) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CAP_RESET;
      count <= '0;
      done  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      count <= count_next;
      done  <= ctrl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_q  <= cmd_t'(cmd);
      pos_q  <= CMP_W'(position);
      word_q <= to_word(value);
    end
    if (ctrl.ptr_load_count) begin
      ptr <= count_ext;
    end else if (ctrl.ptr_load_pos) begin
      ptr <= pos_q;
    end else if (ctrl.ptr_load_zero) begin
      ptr <= '0;
    end else if (ctrl.ptr_dec) begin
      ptr <= ptr_dn;
    end else if (ctrl.ptr_inc) begin
      ptr <= ptr_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      status        <= ctrl.status;
      element_total <= TOT_W'(count_next);
      is_empty      <= (count_next == '0);
      is_full       <= (count_next_ext >= cap_eff);
      case (ctrl.res_sel)
        RES_RDFAIL: begin
          read_value     <= '1;
          found_position <= '0;
        end
        RES_READ: begin
          read_value     <= from_word(rdata);
          found_position <= '0;
        end
        RES_FOUND: begin
          read_value     <= '0;
          found_position <= FND_W'(ptr);
        end
        RES_NOTFOUND: begin
          read_value     <= '0;
          found_position <= '1;
        end
        default: begin
          read_value     <= '0;
          found_position <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/shifting_array_list_engine_unit.sv =====
// Top level of the shifting array list engine: joins the controller and
// the datapath. Depends on sale_pkg, sale_ctrl and sale_datapath.
//
// Channel   Direction  Signals
// request   in         start, busy, cmd, position, value
// result    out        done, status, read_value, found_position,
//                      element_total, is_empty, is_full
// capacity  in         cfg_we, cfg_wdata
//
// A request is taken when start is high and busy is low; its result appears
// with done for one cycle. Insert and delete shift each cell between the
// position and the tail of the list, and a find scans from index 0 until a
// match or the end of the list. Shifts use the single cell memory with
// registered reads: each shift step is one read and one write. Synchronous
// reset clears the count, the controller and the strobe and sets the capacity
// to 64; the cells need no clearing. The receiver cannot stall, and a new
// request may be taken in the cycle its result shows.
`timescale 1ns / 1ps

module shifting_array_list_engine_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [sale_pkg::CMD_W-1:0]        cmd,
  input  logic [sale_pkg::POS_W-1:0]        position,
  input  logic signed [sale_pkg::VAL_W-1:0] value,
  input  logic                              cfg_we,
  input  logic [sale_pkg::CAP_W-1:0]        cfg_wdata,
  output logic                              done,
  output logic [sale_pkg::STAT_W-1:0]       status,
  output logic signed [sale_pkg::VAL_W-1:0] read_value,
  output logic signed [sale_pkg::FND_W-1:0] found_position,
  output logic [sale_pkg::TOT_W-1:0]        element_total,
  output logic                              is_empty,
  output logic                              is_full
);
  import sale_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  sale_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  sale_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .position       (position),
    .value          (value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .ctrl           (ctrl),
    .stat           (stat),
    .done           (done),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .element_total  (element_total),
    .is_empty       (is_empty),
    .is_full        (is_full)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the engine busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.cnt_inc |-> !stat.full)
    else $error("count raised while the list is full");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.cnt_dec |-> !stat.empty)
    else $error("count lowered while the list is empty");
`endif

endmodule

// ===== sim/shifting_array_list_engine_unit_test.sv =====
// Self-checking testbench for shifting_array_list_engine_unit: a directed
// table, then random request phases at several capacities, checked against
// an in-bench list model. Depends on sale_pkg and the RTL top level.
`timescale 1ns / 1ps

module shifting_array_list_engine_unit_test;
  import sale_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 150;
  localparam int NUM_PHASES = 7;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [FND_W-1:0] NO_MATCH = 7'h7F;
  localparam logic [VAL_W-1:0] READ_FAIL = 32'hFFFF_FFFF;

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  read_value;
    logic [FND_W-1:0]  found_position;
    logic [TOT_W-1:0]  element_total;
    logic              is_empty;
    logic              is_full;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             typed;
    list_result_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [CMD_W-1:0] cmd;
  logic [POS_W-1:0] position;
  logic signed [VAL_W-1:0] value;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  logic done;
  logic [STAT_W-1:0] status;
  logic signed [VAL_W-1:0] read_value;
  logic signed [FND_W-1:0] found_position;
  logic [TOT_W-1:0] element_total;
  logic is_empty;
  logic is_full;

  logic [DATA_WIDTH-1:0] list_cells [DEPTH];
  int unsigned list_count = 0;
  logic [CAP_W-1:0] cap_setting = CAP_RESET;
  list_result_t pending_results [$];
  int mismatch_count = 0;
  int stall_cycles;

  int phase_caps [NUM_PHASES] = '{127, 10, 1, 0, 64, 3, 40};
  int phase_items [NUM_PHASES] = '{100, 80, 60, 30, 130, 100, 100};
  int phase_idle [NUM_PHASES] = '{9, 9, 78, 78, 78, 0, 0};

  stim_row_t directed_rows [25] = '{
    '{CMD_READ, 7'd0, 32'd0, 1'b1,
      '{ST_EMPTY, READ_FAIL, 7'd0, 7'd0, 1'b1, 1'b0}},
    '{CMD_DELETE, 7'd0, 32'd0, 1'b1,
      '{ST_EMPTY, 32'd0, 7'd0, 7'd0, 1'b1, 1'b0}},
    '{CMD_OVERWRITE, 7'd5, 32'd7, 1'b1,
      '{ST_EMPTY, 32'd0, 7'd0, 7'd0, 1'b1, 1'b0}},
    '{CMD_FIND, 7'd0, 32'd0, 1'b1,
      '{ST_OK, 32'd0, NO_MATCH, 7'd0, 1'b1, 1'b0}},
    '{CMD_INSERT, 7'd1, 32'd9, 1'b1,
      '{ST_INVALID, 32'd0, 7'd0, 7'd0, 1'b1, 1'b0}},
    '{CMD_SPARE_LO, 7'd0, 32'd0, 1'b1,
      '{ST_OK, 32'd0, 7'd0, 7'd0, 1'b1, 1'b0}},
    '{CMD_SPARE_HI, 7'd127, 32'hFFFF_FFFF, 1'b1,
      '{ST_OK, 32'd0, 7'd0, 7'd0, 1'b1, 1'b0}},
    '{CMD_APPEND, 7'd0, 32'h7FFF_FFFF, 1'b1,
      '{ST_OK, 32'd0, 7'd0, 7'd1, 1'b0, 1'b0}},
    '{CMD_APPEND, 7'd127, 32'h8000_0000, 1'b1,
      '{ST_OK, 32'd0, 7'd0, 7'd2, 1'b0, 1'b0}},
    '{CMD_INSERT, 7'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_INSERT, 7'd3, 32'd0, 1'b0, '0},
    '{CMD_INSERT, 7'd127, 32'd5, 1'b1,
      '{ST_INVALID, 32'd0, 7'd0, 7'd4, 1'b0, 1'b0}},
    '{CMD_READ, 7'd0, 32'd0, 1'b0, '0},
    '{CMD_READ, 7'd3, 32'd0, 1'b0, '0},
    '{CMD_READ, 7'd127, 32'd0, 1'b1,
      '{ST_INVALID, READ_FAIL, 7'd0, 7'd4, 1'b0, 1'b0}},
    '{CMD_OVERWRITE, 7'd1, 32'h5555_5555, 1'b0, '0},
    '{CMD_OVERWRITE, 7'd4, 32'hAAAA_AAAA, 1'b1,
      '{ST_INVALID, 32'd0, 7'd0, 7'd4, 1'b0, 1'b0}},
    '{CMD_FIND, 7'd0, 32'h8000_0000, 1'b0, '0},
    '{CMD_FIND, 7'd0, 32'd12345, 1'b0, '0},
    '{CMD_DELETE, 7'd127, 32'd0, 1'b1,
      '{ST_INVALID, 32'd0, 7'd0, 7'd4, 1'b0, 1'b0}},
    '{CMD_DELETE, 7'd0, 32'd0, 1'b0, '0},
    '{CMD_DELETE, 7'd2, 32'd0, 1'b0, '0},
    '{CMD_READ, 7'd1, 32'd0, 1'b0, '0},
    '{CMD_SPARE_HI, 7'd64, 32'h1234_5678, 1'b0, '0},
    '{CMD_FIND, 7'd0, 32'h5555_5555, 1'b0, '0}
  };

  shifting_array_list_engine_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .position       (position),
    .value          (value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .done           (done),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .element_total  (element_total),
    .is_empty       (is_empty),
    .is_full        (is_full)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic list_result_t apply_command(input logic [CMD_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    list_result_t r;
    int unsigned limit;
    logic [DATA_WIDTH-1:0] word;
    logic at_limit;
    logic no_items;
    logic hit;
    limit = (cap_setting > DEPTH) ? DEPTH : cap_setting;
    word = DATA_WIDTH'(signed'(val));
    at_limit = list_count >= limit;
    no_items = list_count == 0;
    hit = 1'b0;
    r = '0;
    r.status = ST_OK;
    case (op)
      CMD_APPEND: begin
        if (at_limit) begin
          r.status = ST_FULL;
        end else begin
          list_cells[IDX_W'(list_count)] = word;
          list_count++;
        end
      end
      CMD_INSERT: begin
        if (at_limit) begin
          r.status = ST_FULL;
        end else if (pos > list_count) begin
          r.status = ST_INVALID;
        end else begin
          for (int i = list_count; i > pos; i--) begin
            list_cells[IDX_W'(i)] = list_cells[IDX_W'(i - 1)];
          end
          list_cells[pos[IDX_W-1:0]] = word;
          list_count++;
        end
      end
      CMD_DELETE: begin
        if (no_items) begin
          r.status = ST_EMPTY;
        end else if (pos >= list_count) begin
          r.status = ST_INVALID;
        end else begin
          for (int i = pos; i + 1 < list_count; i++) begin
            list_cells[IDX_W'(i)] = list_cells[IDX_W'(i + 1)];
          end
          list_count--;
        end
      end
      CMD_READ: begin
        if (no_items) begin
          r.status = ST_EMPTY;
          r.read_value = READ_FAIL;
        end else if (pos >= list_count) begin
          r.status = ST_INVALID;
          r.read_value = READ_FAIL;
        end else begin
          r.read_value = VAL_W'(signed'(list_cells[pos[IDX_W-1:0]]));
        end
      end
      CMD_OVERWRITE: begin
        if (no_items) begin
          r.status = ST_EMPTY;
        end else if (pos >= list_count) begin
          r.status = ST_INVALID;
        end else begin
          list_cells[pos[IDX_W-1:0]] = word;
        end
      end
      CMD_FIND: begin
        r.found_position = NO_MATCH;
        for (int i = 0; i < list_count && !hit; i++) begin
          if (list_cells[IDX_W'(i)] == word) begin
            r.found_position = FND_W'(i);
            hit = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.element_total = TOT_W'(list_count);
    r.is_empty = list_count == 0;
    r.is_full = list_count >= limit;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] random_word();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 5) return VAL_W'($urandom_range(7)) - VAL_W'(3);
    else if (kind < 8) return VAL_W'($urandom);
    else if (kind == 8) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    else return $urandom_range(1) ? {VAL_W{1'b1}} : {VAL_W{1'b0}};
  endfunction

  // Positions and find keys are mostly drawn from the live part of the list so
  // that shifts and matches dominate; the rest probe the error paths.
  function automatic void choose_request(output logic [CMD_W-1:0] op,
                                         output logic [POS_W-1:0] pos,
                                         output logic [VAL_W-1:0] val);
    int unsigned pick;
    pick = $urandom_range(99);
    val = random_word();
    if (list_count != 0 && $urandom_range(9) < 8) pos = POS_W'($urandom_range(list_count - 1));
    else pos = POS_W'($urandom_range(127));
    if (pick < 22) begin
      op = CMD_APPEND;
    end else if (pick < 42) begin
      op = CMD_INSERT;
      if ($urandom_range(9) < 8) pos = POS_W'($urandom_range(list_count));
    end else if (pick < 60) begin
      op = CMD_DELETE;
    end else if (pick < 72) begin
      op = CMD_READ;
    end else if (pick < 82) begin
      op = CMD_OVERWRITE;
    end else if (pick < 97) begin
      op = CMD_FIND;
      if (list_count != 0 && $urandom_range(9) < 7)
        val = VAL_W'(list_cells[IDX_W'($urandom_range(list_count - 1))]);
    end else begin
      op = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
    end
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val, input logic use_typed,
                              input list_result_t typed_want, input int idle_pct);
    list_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    position <= pos;
    value <= val;
    do @(posedge clk); while (busy);
    predicted = apply_command(op, pos, val);
    pending_results.push_back(use_typed ? typed_want : predicted);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_setting = cap;
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result strobe with no request pending");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          mismatch_count++;
          $error("status: expected %0d, got %0d", want.status, status);
        end
        if (read_value !== want.read_value) begin
          mismatch_count++;
          $error("read_value: expected %h, got %h", want.read_value, read_value);
        end
        if (found_position !== want.found_position) begin
          mismatch_count++;
          $error("found_position: expected %h, got %h", want.found_position, found_position);
        end
        if (element_total !== want.element_total) begin
          mismatch_count++;
          $error("element_total: expected %0d, got %0d", want.element_total, element_total);
        end
        if (is_empty !== want.is_empty) begin
          mismatch_count++;
          $error("is_empty: expected %b, got %b", want.is_empty, is_empty);
        end
        if (is_full !== want.is_full) begin
          mismatch_count++;
          $error("is_full: expected %b, got %b", want.is_full, is_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : main
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    position = '0;
    value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].want, 9);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_capacity(CAP_W'(phase_caps[p]));
      for (int n = 0; n < phase_items[p]; n++) begin
        choose_request(op, pos, val);
        send_request(op, pos, val, 1'b0, '0, phase_idle[p]);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
